### hw/rtl/aic_pkg.sv
// Shared types and constants of the ASCII integer calculator.
package aic_pkg;

    localparam int CHAR_W    = 8;
    localparam int EVENT_W   = 3;
    localparam int RESULT_W  = 32;
    localparam int IN_DATA_W = 8;
    localparam int TDATA_W   = 40;
    localparam int TUSER_W   = 4;

    localparam logic [CHAR_W-1:0] C_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] C_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] C_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] C_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] C_QUIT    = 8'h71;
    localparam logic [CHAR_W-1:0] C_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] C_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] C_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] C_NINE    = 8'h39;

    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RESULT  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DIVZERO = 3'd2;
    localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd3;
    localparam logic [EVENT_W-1:0] EV_QUIT    = 3'd4;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_FIRST  = 6'b000010,
        PH_SP1    = 6'b000100,
        PH_SP2    = 6'b001000,
        PH_SECOND = 6'b010000,
        PH_SKIP   = 6'b100000
    } t_phase;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_NEGA   = 10'b0000000010,
        ST_NEGB   = 10'b0000000100,
        ST_ADDSUB = 10'b0000001000,
        ST_MUL    = 10'b0000010000,
        ST_ABSA   = 10'b0000100000,
        ST_ABSB   = 10'b0001000000,
        ST_DIV    = 10'b0010000000,
        ST_SIGN   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } t_state;

endpackage

### hw/rtl/ascii_integer_calculator_core.sv
// Top level of the ASCII integer calculator: line parser and shared-adder sequencer.
// A character other than a line-ending newline gives its word in the cycle after accept.
// A line-ending newline runs NEGA and NEGB, then ADDSUB for + and -, MUL (shift-add) for *
// or ABSA, ABSB, DIV (restoring division), SIGN for /, all on one shared adder/subtractor.
// Throughput: one word per cycle while the output slot is free, none while calculating.
// Reset: synchronous, active low; clears the parser to line start and empties the output.
module ascii_integer_calculator_core
    import aic_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [7:0] char_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [7:0] echo_char, [39:8] result_value
    output logic [TUSER_W-1:0]   m_axis_tuser    // [0] echo_valid, [3:1] event_res
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH);

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [W-1:0]       r_m1, n_m1;
    logic               r_neg1, n_neg1;
    logic [CHAR_W-1:0]  r_op, n_op;
    logic [W-1:0]       r_m2, n_m2;
    logic               r_neg2, n_neg2;

    logic [W-1:0]       r_x, n_x;
    logic [W-1:0]       r_y, n_y;
    logic [W-1:0]       r_acc, n_acc;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_qneg, n_qneg;
    logic [EVENT_W-1:0] r_ev, n_ev;

    logic                r_m_valid;
    logic                r_o_echo_valid;
    logic [CHAR_W-1:0]   r_o_echo_char;
    logic [EVENT_W-1:0]  r_o_event;
    logic [RESULT_W-1:0] r_o_result;

    logic                w_slot_free;
    logic                w_accept;
    logic [CHAR_W-1:0]   w_c;
    logic                w_digit;
    logic                w_is_start;
    logic                w_go_first;
    logic                w_go_sp1;
    logic                w_go_second;
    logic                w_go_skip;
    logic                w_echo;
    logic [EVENT_W-1:0]  w_event;
    logic                w_launch;
    logic                w_done_load;
    logic [W-1:0]        w_digit_val;

    logic [W:0]          w_ua;
    logic [W:0]          w_ub;
    logic                w_sub;
    logic [W:0]          w_sum;
    logic                w_ge;
    logic [RESULT_W-1:0] w_res32;

    assign w_slot_free   = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_c           = s_axis_tdata[CHAR_W-1:0];
    assign w_digit       = (w_c >= C_ZERO) && (w_c <= C_NINE);
    assign w_digit_val   = {{(W-4){1'b0}}, w_c[3:0]};
    assign w_done_load   = (r_state == ST_DONE) && w_slot_free;

    // Line parser.
    always_comb begin
        case (r_phase)
            PH_FIRST, PH_SP1, PH_SP2, PH_SECOND, PH_SKIP: w_is_start = 1'b0;
            default: w_is_start = 1'b1;
        endcase
        w_go_first  = (w_is_start && (w_c != C_QUIT) && (w_c != C_MINUS))
                      || (r_phase == PH_FIRST);
        w_go_sp1    = (w_go_first && !w_digit) || (r_phase == PH_SP1);
        w_go_second = ((r_phase == PH_SP2) && (w_c != C_SPACE) && (w_c != C_MINUS))
                      || (r_phase == PH_SECOND);
        w_go_skip   = (w_go_second && !w_digit) || (r_phase == PH_SKIP);

        n_phase  = r_phase;
        n_m1     = r_m1;
        n_neg1   = r_neg1;
        n_op     = r_op;
        n_m2     = r_m2;
        n_neg2   = r_neg2;
        w_echo   = 1'b0;
        w_event  = EV_NONE;
        w_launch = 1'b0;

        if (w_is_start && (w_c == C_QUIT)) begin
            w_echo  = 1'b1;
            w_event = EV_QUIT;
            n_phase = PH_START;
        end else if (w_is_start && (w_c == C_MINUS)) begin
            w_echo  = 1'b1;
            n_neg1  = 1'b1;
            n_phase = PH_FIRST;
        end
        if (w_go_first && w_digit) begin
            n_m1    = {r_m1[W-4:0], 3'b000} + {r_m1[W-2:0], 1'b0} + w_digit_val;
            w_echo  = 1'b1;
            n_phase = PH_FIRST;
        end
        if (w_go_sp1) begin
            w_echo = 1'b1;
            if (w_c == C_SPACE) begin
                n_phase = PH_SP1;
            end else begin
                n_op    = w_c;
                n_phase = PH_SP2;
            end
        end
        if (r_phase == PH_SP2) begin
            if (w_c == C_SPACE) begin
                w_echo = 1'b1;
            end else if (w_c == C_MINUS) begin
                w_echo  = 1'b1;
                n_neg2  = 1'b1;
                n_phase = PH_SECOND;
            end
        end
        if (w_go_second && w_digit) begin
            n_m2    = {r_m2[W-4:0], 3'b000} + {r_m2[W-2:0], 1'b0} + w_digit_val;
            w_echo  = 1'b1;
            n_phase = PH_SECOND;
        end
        if (w_go_skip) begin
            n_phase = PH_SKIP;
            if (w_c == C_NEWLINE) begin
                w_echo   = 1'b1;
                w_launch = 1'b1;
            end
        end
    end

    // Shared adder/subtractor operand selection.
    always_comb begin
        w_ua  = '0;
        w_ub  = '0;
        w_sub = 1'b0;
        case (r_state)
            ST_NEGA: begin
                w_ub  = {1'b0, r_m1};
                w_sub = r_neg1;
            end
            ST_NEGB: begin
                w_ub  = {1'b0, r_m2};
                w_sub = r_neg2;
            end
            ST_ADDSUB: begin
                w_ua  = {1'b0, r_x};
                w_ub  = {1'b0, r_y};
                w_sub = (r_op == C_MINUS);
            end
            ST_MUL: begin
                w_ua = {1'b0, r_acc};
                w_ub = {1'b0, r_x};
            end
            ST_ABSA: begin
                w_ub  = {1'b0, r_x};
                w_sub = r_x[W-1];
            end
            ST_ABSB: begin
                w_ub  = {1'b0, r_y};
                w_sub = r_y[W-1];
            end
            ST_DIV: begin
                w_ua  = {r_acc, r_x[W-1]};
                w_ub  = {1'b0, r_y};
                w_sub = 1'b1;
            end
            ST_SIGN: begin
                w_ub  = {1'b0, r_x};
                w_sub = r_qneg;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum   = w_ua + (w_sub ? ~w_ub : w_ub) + {{W{1'b0}}, w_sub};
    assign w_ge    = !w_sum[W];
    assign w_res32 = RESULT_W'($signed(r_acc));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_qneg  = r_qneg;
        n_ev    = r_ev;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_launch) begin
                    n_state = ST_NEGA;
                end
            end
            ST_NEGA: begin
                n_x     = w_sum[W-1:0];
                n_state = ST_NEGB;
            end
            ST_NEGB: begin
                n_y   = w_sum[W-1:0];
                n_acc = '0;
                n_cnt = CW'(VALUE_WIDTH - 1);
                n_ev  = EV_RESULT;
                if ((r_op == C_PLUS) || (r_op == C_MINUS)) begin
                    n_state = ST_ADDSUB;
                end else if (r_op == C_STAR) begin
                    n_state = ST_MUL;
                end else if (r_op == C_SLASH) begin
                    if (w_sum[W-1:0] == '0) begin
                        n_ev    = EV_DIVZERO;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ABSA;
                    end
                end else begin
                    n_ev    = EV_UNKNOWN;
                    n_state = ST_DONE;
                end
            end
            ST_ADDSUB: begin
                n_acc   = w_sum[W-1:0];
                n_state = ST_DONE;
            end
            ST_MUL: begin
                if (r_y[0]) begin
                    n_acc = w_sum[W-1:0];
                end
                n_x = {r_x[W-2:0], 1'b0};
                n_y = {1'b0, r_y[W-1:1]};
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_ABSA: begin
                n_qneg  = r_x[W-1] ^ r_y[W-1];
                n_x     = w_sum[W-1:0];
                n_state = ST_ABSB;
            end
            ST_ABSB: begin
                n_y     = w_sum[W-1:0];
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_acc = w_ge ? w_sum[W-1:0] : {r_acc[W-2:0], r_x[W-1]};
                n_x   = {r_x[W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = ST_SIGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SIGN: begin
                n_acc   = w_sum[W-1:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_START;
            r_m1    <= '0;
            r_neg1  <= 1'b0;
            r_op    <= '0;
            r_m2    <= '0;
            r_neg2  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done_load) begin
                r_phase <= PH_START;
                r_m1    <= '0;
                r_neg1  <= 1'b0;
                r_op    <= '0;
                r_m2    <= '0;
                r_neg2  <= 1'b0;
            end else if (w_accept) begin
                r_phase <= n_phase;
                r_m1    <= n_m1;
                r_neg1  <= n_neg1;
                r_op    <= n_op;
                r_m2    <= n_m2;
                r_neg2  <= n_neg2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_qneg <= n_qneg;
        r_ev   <= n_ev;
    end

    // Output register: load on a direct word or at the end of a calculation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((w_accept && !w_launch) || w_done_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_load) begin
            r_o_echo_valid <= 1'b1;
            r_o_echo_char  <= C_NEWLINE;
            r_o_event      <= r_ev;
            r_o_result     <= (r_ev == EV_RESULT) ? w_res32 : '0;
        end else if (w_accept && !w_launch) begin
            r_o_echo_valid <= w_echo;
            r_o_echo_char  <= w_echo ? w_c : '0;
            r_o_event      <= w_event;
            r_o_result     <= '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_o_result, r_o_echo_char};
    assign m_axis_tuser  = {r_o_event, r_o_echo_valid};

endmodule

### hw/rtl/aic_checker.sv
// Port-level checker of the ASCII integer calculator and its bind.
module aic_checker
    import aic_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [IN_DATA_W-1:0] s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [TDATA_W-1:0]   m_axis_tdata,
    input logic [TUSER_W-1:0]   m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_direct_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata != C_NEWLINE) |=> m_axis_tvalid)
        else $error("no word one cycle after a non-newline character");

    a_quit_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] == EV_QUIT) |->
            m_axis_tuser[0] && (m_axis_tdata[7:0] == C_QUIT))
        else $error("quit event without echoed quit character");

    a_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] != EV_RESULT) |-> (m_axis_tdata[39:8] == '0))
        else $error("non-zero value without a result event");

    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[7:0] == '0))
        else $error("echo character set without echo");

endmodule

bind ascii_integer_calculator_core aic_checker u_aic_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/testbench.sv
// Self-checking testbench for the ASCII integer calculator core.
module testbench;
    import aic_pkg::*;

    localparam int RANDOM_CHARS = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 50;

    typedef struct packed {
        logic                echo_valid;
        logic [CHAR_W-1:0]   echo_char;
        logic [EVENT_W-1:0]  event_code;
        logic [RESULT_W-1:0] value;
    } t_reply;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        bit                typed;
        t_reply            reply;
    } t_stim_row;

    localparam t_reply NO_CHECK = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;   // [7:0] char_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;   // [7:0] echo_char, [39:8] result_value
    logic [TUSER_W-1:0]   m_axis_tuser;   // [0] echo_valid, [3:1] event_res

    ascii_integer_calculator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Calculator state as seen from outside
    t_phase            calc_phase = PH_START;
    logic [31:0]       lhs_mag    = '0;
    logic [31:0]       rhs_mag    = '0;
    bit                lhs_neg    = 1'b0;
    bit                rhs_neg    = 1'b0;
    logic [CHAR_W-1:0] op_char    = '0;

    t_reply pending_replies[$];
    int     chars_sent    = 0;
    int     words_checked = 0;
    int     mismatches    = 0;
    int     burst_left    = 0;
    int     cycle_count   = 0;
    int     event_seen[5] = '{default: 0};
    int     stall_tick    = 0;
    int     sink_mode     = 0;

    t_stim_row directed_rows[29] = '{
        '{C_QUIT,    1'b1, '{1'b1, C_QUIT, EV_QUIT, 32'd0}},
        '{"2", 1'b0, NO_CHECK}, '{"1", 1'b0, NO_CHECK}, '{"4", 1'b0, NO_CHECK},
        '{"7", 1'b0, NO_CHECK}, '{"4", 1'b0, NO_CHECK}, '{"8", 1'b0, NO_CHECK},
        '{"3", 1'b0, NO_CHECK}, '{"6", 1'b0, NO_CHECK}, '{"4", 1'b0, NO_CHECK},
        '{"8", 1'b0, NO_CHECK}, '{C_SLASH, 1'b0, NO_CHECK}, '{C_MINUS, 1'b0, NO_CHECK},
        '{"1", 1'b0, NO_CHECK},
        '{C_NEWLINE, 1'b1, '{1'b1, C_NEWLINE, EV_RESULT, 32'h8000_0000}},
        '{C_NEWLINE, 1'b0, NO_CHECK},
        '{C_NEWLINE, 1'b1, '{1'b1, C_NEWLINE, EV_UNKNOWN, 32'd0}},
        '{"7", 1'b0, NO_CHECK}, '{C_SLASH, 1'b0, NO_CHECK}, '{C_MINUS, 1'b0, NO_CHECK},
        '{"0", 1'b0, NO_CHECK},
        '{C_NEWLINE, 1'b1, '{1'b1, C_NEWLINE, EV_DIVZERO, 32'd0}},
        '{C_STAR, 1'b0, NO_CHECK},
        '{C_NEWLINE, 1'b1, '{1'b1, C_NEWLINE, EV_RESULT, 32'd0}},
        '{C_PLUS, 1'b0, NO_CHECK},
        '{C_NEWLINE, 1'b1, '{1'b1, C_NEWLINE, EV_RESULT, 32'd0}},
        '{"9", 1'b0, NO_CHECK}, '{C_MINUS, 1'b0, NO_CHECK},
        '{C_NEWLINE, 1'b1, '{1'b1, C_NEWLINE, EV_RESULT, 32'd9}}
    };

    function automatic bit is_digit(input logic [CHAR_W-1:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic t_reply calculate_reply(input logic [CHAR_W-1:0] c);
        t_reply      r;
        bit          handled;
        logic [31:0] a, b, abs_a, abs_b, q;
        r       = '0;
        handled = 1'b0;
        if (calc_phase == PH_START) begin
            if (c == C_QUIT) begin
                r.echo_valid = 1'b1;
                r.event_code = EV_QUIT;
                handled      = 1'b1;
            end else if (c == C_MINUS) begin
                lhs_neg      = 1'b1;
                r.echo_valid = 1'b1;
                calc_phase   = PH_FIRST;
                handled      = 1'b1;
            end else begin
                calc_phase = PH_FIRST;
            end
        end
        if (!handled && calc_phase == PH_FIRST) begin
            if (is_digit(c)) begin
                lhs_mag      = lhs_mag * 32'd10 + 32'(c - C_ZERO);
                r.echo_valid = 1'b1;
                handled      = 1'b1;
            end else begin
                calc_phase = PH_SP1;
            end
        end
        if (!handled && calc_phase == PH_SP1) begin
            if (c != C_SPACE) begin
                op_char    = c;
                calc_phase = PH_SP2;
            end
            r.echo_valid = 1'b1;
            handled      = 1'b1;
        end
        if (!handled && calc_phase == PH_SP2) begin
            if (c == C_SPACE) begin
                r.echo_valid = 1'b1;
                handled      = 1'b1;
            end else if (c == C_MINUS) begin
                rhs_neg      = 1'b1;
                r.echo_valid = 1'b1;
                calc_phase   = PH_SECOND;
                handled      = 1'b1;
            end else begin
                calc_phase = PH_SECOND;
            end
        end
        if (!handled && calc_phase == PH_SECOND) begin
            if (is_digit(c)) begin
                rhs_mag      = rhs_mag * 32'd10 + 32'(c - C_ZERO);
                r.echo_valid = 1'b1;
                handled      = 1'b1;
            end else begin
                calc_phase = PH_SKIP;
            end
        end
        if (!handled && calc_phase == PH_SKIP && c == C_NEWLINE) begin
            a            = lhs_neg ? -lhs_mag : lhs_mag;
            b            = rhs_neg ? -rhs_mag : rhs_mag;
            r.echo_valid = 1'b1;
            r.event_code = EV_RESULT;
            case (op_char)
                C_PLUS:  r.value = a + b;
                C_MINUS: r.value = a - b;
                C_STAR:  r.value = a * b;
                C_SLASH: begin
                    if (b == 0) begin
                        r.event_code = EV_DIVZERO;
                    end else begin
                        abs_a   = a[31] ? -a : a;
                        abs_b   = b[31] ? -b : b;
                        q       = abs_a / abs_b;
                        r.value = (a[31] ^ b[31]) ? -q : q;
                    end
                end
                default: r.event_code = EV_UNKNOWN;
            endcase
            calc_phase = PH_START;
            lhs_mag    = '0;
            rhs_mag    = '0;
            lhs_neg    = 1'b0;
            rhs_neg    = 1'b0;
            op_char    = '0;
        end
        if (r.echo_valid)
            r.echo_char = c;
        return r;
    endfunction

    task automatic type_char(input logic [CHAR_W-1:0] c, input bit typed,
                             input t_reply typed_reply);
        t_reply predicted;
        int     gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = calculate_reply(c);
        pending_replies.push_back(typed ? typed_reply : predicted);
        chars_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid = 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic type_digits(input int n, input bit zeros);
        for (int k = 0; k < n; k++)
            type_char(zeros ? C_ZERO : C_ZERO + 8'($urandom_range(0, 9)), 1'b0, NO_CHECK);
    endtask

    task automatic type_line();
        int                kind, pick, n;
        logic [CHAR_W-1:0] op;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            type_char(C_QUIT, 1'b0, NO_CHECK);
        end else if (kind == 1) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                type_char(8'($urandom_range(0, 255)), 1'b0, NO_CHECK);
            type_char(C_NEWLINE, 1'b0, NO_CHECK);
        end else begin
            if ($urandom_range(0, 2) == 0)
                type_char(C_MINUS, 1'b0, NO_CHECK);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
            type_digits(n, 1'b0);
            repeat ($urandom_range(0, 2)) type_char(C_SPACE, 1'b0, NO_CHECK);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1:    op = C_PLUS;
                2, 3:    op = C_MINUS;
                4, 5:    op = C_STAR;
                6, 7:    op = C_SLASH;
                8:       op = C_NEWLINE;
                default: op = 8'($urandom_range(0, 255));
            endcase
            type_char(op, 1'b0, NO_CHECK);
            repeat ($urandom_range(0, 2)) type_char(C_SPACE, 1'b0, NO_CHECK);
            if ($urandom_range(0, 2) == 0)
                type_char(C_MINUS, 1'b0, NO_CHECK);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
            type_digits(n, op == C_SLASH && $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) type_char(8'($urandom_range(0, 255)), 1'b0,
                                                        NO_CHECK);
            type_char(C_NEWLINE, 1'b0, NO_CHECK);
        end
    endtask

    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0)
            sink_mode = $urandom_range(0, 3);
        case (sink_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= stall_tick[3];
        endcase
    end

    always @(posedge i_clk) begin : check_words
        t_reply got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tuser[3:1], m_axis_tdata[39:8]};
            words_checked++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: echo %0b char %02h event %0d value %08h",
                             got.echo_valid, got.echo_char, got.event_code, got.value);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: expected echo %0b char %02h event %0d value %08h,",
                               want.echo_valid, want.echo_char, want.event_code, want.value);
                        $display(" got echo %0b char %02h event %0d value %08h",
                                 got.echo_valid, got.echo_char, got.event_code, got.value);
                    end
                end
                if (want.event_code <= EV_QUIT)
                    event_seen[want.event_code]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int next_drain;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            type_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].reply);
        hold_until_drained();

        next_drain = chars_sent + $urandom_range(100, 200);
        while (chars_sent < RANDOM_CHARS + $size(directed_rows)) begin
            type_line();
            if (chars_sent >= next_drain) begin
                hold_until_drained();
                next_drain = chars_sent + $urandom_range(100, 200);
            end
        end
        hold_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("%0d characters typed, %0d words checked, %0d mismatches",
                 chars_sent, words_checked, mismatches);
        $display("events: %0d results, %0d division by zero, %0d unknown operator, %0d quit",
                 event_seen[EV_RESULT], event_seen[EV_DIVZERO], event_seen[EV_UNKNOWN],
                 event_seen[EV_QUIT]);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
